FILE: design/gfr_pkg.sv
// Shared types, codes and constants for the frame receiver and acknowledge tracker.
`timescale 1ns / 1ps
`default_nettype none
package gfr_pkg;

    localparam logic [7:0]  SYNC_FIRST    = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND   = 8'h62;
    localparam logic [7:0]  ACK_CLASS     = 8'h05;
    localparam logic [7:0]  ACK_ID_ACK    = 8'h01;
    localparam logic [15:0] ACK_LEN       = 16'd2;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_ISSUE = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        STAT_IDLE    = 3'd0,
        STAT_WAITING = 3'd1,
        STAT_ACKED   = 3'd2,
        STAT_NACKED  = 3'd3,
        STAT_TIMEOUT = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_ACK  = 2'd1,
        EV_NAK  = 2'd2
    } t_ack_ev;

    typedef enum logic [8:0] {
        PH_SYNC1   = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_CLASS   = 9'b000000100,
        PH_ID      = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CK_A    = 9'b010000000,
        PH_CK_B    = 9'b100000000
    } t_phase;

    typedef enum logic [4:0] {
        TRK_IDLE    = 5'b00001,
        TRK_WAITING = 5'b00010,
        TRK_ACKED   = 5'b00100,
        TRK_NACKED  = 5'b01000,
        TRK_TIMEOUT = 5'b10000
    } t_trk;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        logic        frame_ok;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] msg_length;
        logic [7:0]  ack_first;
        logic [7:0]  ack_second;
    } t_rx_res;

    function automatic t_status status_code(input t_trk st);
        t_status code;
        case (st)
            TRK_IDLE:    code = STAT_IDLE;
            TRK_WAITING: code = STAT_WAITING;
            TRK_ACKED:   code = STAT_ACKED;
            TRK_NACKED:  code = STAT_NACKED;
            TRK_TIMEOUT: code = STAT_TIMEOUT;
            default:     code = STAT_IDLE;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

FILE: design/gfr_frame_rx.sv
// Byte parser: sync hunt, header fields, running Fletcher sum and frame check.
`timescale 1ns / 1ps
`default_nettype none
module gfr_frame_rx
    import gfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire logic    i_is_byte,
    input  wire logic [7:0] i_byte,
    output t_rx_res      o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_got_a, n_got_a;
    logic [7:0]  r_ack_first, n_ack_first;
    logic [7:0]  r_ack_second, n_ack_second;
    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [15:0] count_inc;

    assign add_a     = r_sum_a + i_byte;
    assign add_b     = r_sum_b + add_a;
    assign count_inc = r_count + 16'd1;

    always_comb begin
        n_phase      = r_phase;
        n_class      = r_class;
        n_id         = r_id;
        n_len        = r_len;
        n_count      = r_count;
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        n_got_a      = r_got_a;
        n_ack_first  = r_ack_first;
        n_ack_second = r_ack_second;
        o_res.payload_valid = 1'b0;
        o_res.payload_byte  = 8'd0;
        o_res.frame_done    = 1'b0;
        o_res.frame_ok      = 1'b0;
        if (i_is_byte) begin
            case (r_phase)
                PH_SYNC1: begin
                    if (i_byte == SYNC_FIRST) begin
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    if (i_byte == SYNC_SECOND) begin
                        n_phase = PH_CLASS;
                        n_sum_a = 8'd0;
                        n_sum_b = 8'd0;
                    end else if (i_byte != SYNC_FIRST) begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_CLASS: begin
                    n_class = i_byte;
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = PH_ID;
                end
                PH_ID: begin
                    n_id    = i_byte;
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = {8'd0, i_byte};
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len   = {i_byte, r_len[7:0]};
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_count = 16'd0;
                    n_phase = ({i_byte, r_len[7:0]} == 16'd0) ? PH_CK_A : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    o_res.payload_valid = 1'b1;
                    o_res.payload_byte  = i_byte;
                    if (r_count == 16'd0) begin
                        n_ack_first = i_byte;
                    end else if (r_count == 16'd1) begin
                        n_ack_second = i_byte;
                    end
                    n_count = count_inc;
                    if (count_inc >= r_len) begin
                        n_phase = PH_CK_A;
                    end
                end
                PH_CK_A: begin
                    n_got_a = i_byte;
                    n_phase = PH_CK_B;
                end
                PH_CK_B: begin
                    o_res.frame_done = 1'b1;
                    o_res.frame_ok   = (r_got_a == r_sum_a) && (i_byte == r_sum_b);
                    n_phase          = PH_SYNC1;
                end
                default: begin
                    n_phase = PH_SYNC1;
                end
            endcase
        end
        o_res.msg_class  = n_class;
        o_res.msg_id     = n_id;
        o_res.msg_length = n_len;
        o_res.ack_first  = r_ack_first;
        o_res.ack_second = r_ack_second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SYNC1;
            r_class      <= 8'd0;
            r_id         <= 8'd0;
            r_len        <= 16'd0;
            r_count      <= 16'd0;
            r_sum_a      <= 8'd0;
            r_sum_b      <= 8'd0;
            r_got_a      <= 8'd0;
            r_ack_first  <= 8'd0;
            r_ack_second <= 8'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_class      <= n_class;
            r_id         <= n_id;
            r_len        <= n_len;
            r_count      <= n_count;
            r_sum_a      <= n_sum_a;
            r_sum_b      <= n_sum_b;
            r_got_a      <= n_got_a;
            r_ack_first  <= n_ack_first;
            r_ack_second <= n_ack_second;
        end
    end

endmodule
`default_nettype wire

FILE: design/gfr_cmd_track.sv
// Command tracker: issue, acknowledge match, tick count and timeout.
`timescale 1ns / 1ps
`default_nettype none
module gfr_cmd_track
    import gfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_step,
    input  wire logic [1:0]  i_req,
    input  wire logic [7:0]  i_cmd_class,
    input  wire logic [7:0]  i_cmd_id,
    input  wire t_rx_res     i_rx,
    output logic             o_accepted,
    output logic [2:0]       o_status,
    output logic [1:0]       o_ack_ev
);

    logic [15:0] r_timeout;
    t_trk        r_state, n_state;
    logic [7:0]  r_pend_class, n_pend_class;
    logic [7:0]  r_pend_id, n_pend_id;
    logic [15:0] r_elapsed, n_elapsed;
    t_ack_ev     ack_ev;
    logic        ack_match;

    assign ack_match = i_rx.frame_done && i_rx.frame_ok && (i_rx.msg_class == ACK_CLASS)
                     && (i_rx.msg_length == ACK_LEN) && (r_state == TRK_WAITING)
                     && (i_rx.ack_first == r_pend_class) && (i_rx.ack_second == r_pend_id);

    always_comb begin
        n_state      = r_state;
        n_pend_class = r_pend_class;
        n_pend_id    = r_pend_id;
        n_elapsed    = r_elapsed;
        o_accepted   = 1'b0;
        ack_ev       = EV_NONE;
        case (i_req)
            REQ_BYTE: begin
                if (ack_match) begin
                    if (i_rx.msg_id == ACK_ID_ACK) begin
                        n_state = TRK_ACKED;
                        ack_ev  = EV_ACK;
                    end else begin
                        n_state = TRK_NACKED;
                        ack_ev  = EV_NAK;
                    end
                end
            end
            REQ_ISSUE: begin
                if (r_state != TRK_WAITING) begin
                    n_pend_class = i_cmd_class;
                    n_pend_id    = i_cmd_id;
                    n_state      = TRK_WAITING;
                    n_elapsed    = 16'd0;
                    o_accepted   = 1'b1;
                end
            end
            REQ_TICK: begin
                if (r_state == TRK_WAITING) begin
                    if (r_elapsed != ELAPSED_MAX) begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                    if (n_elapsed >= r_timeout) begin
                        n_state = TRK_TIMEOUT;
                    end
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
        o_status = status_code(n_state);
        o_ack_ev = ack_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= TRK_IDLE;
            r_pend_class <= 8'd0;
            r_pend_id    <= 8'd0;
            r_elapsed    <= 16'd0;
        end else if (i_step) begin
            r_state      <= n_state;
            r_pend_class <= n_pend_class;
            r_pend_id    <= n_pend_id;
            r_elapsed    <= n_elapsed;
        end
    end

endmodule
`default_nettype wire

FILE: design/gnss_frame_receiver_ack_tracker.sv
// Top level: input word register, frame parser, command tracker and result register.
//
//  Channel | Direction | Handshake                  | Word
//  in      | input     | i_in_valid / o_in_stall    | req_type, rx_byte, cmd_class, cmd_id
//  out     | output    | o_out_valid / i_out_stall  | payload, frame, header, command fields
//  cfg     | input     | i_cfg_wr_en                | timeout_ticks (16 bit)
//
// One word per cycle sustained while i_out_stall is low; a result word goes through the input
// register, then the result register, to o_out_valid and leaves when i_out_stall is low.
// Reset is synchronous, active low: parser hunts for the first sync byte, tracker idle,
// timeout 1000 ticks. The result register stalls on i_out_stall; the input register then
// fills and o_in_stall rises, so no word is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module gnss_frame_receiver_ack_tracker
    import gfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [7:0]  i_cmd_class,
    input  wire logic [7:0]  i_cmd_id,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_payload_valid,
    output logic [7:0]       o_payload_byte,
    output logic             o_frame_done,
    output logic             o_frame_ok,
    output logic [7:0]       o_msg_class,
    output logic [7:0]       o_msg_id,
    output logic [15:0]      o_msg_length,
    output logic             o_cmd_accepted,
    output logic [2:0]       o_cmd_status,
    output logic [1:0]       o_ack_event
);

    logic        r_in_valid;
    logic [1:0]  r_req;
    logic [7:0]  r_byte;
    logic [7:0]  r_cmd_class;
    logic [7:0]  r_cmd_id;
    logic        r_out_valid;
    logic        advance;
    logic        step;
    logic        in_take;
    t_rx_res     rx_res;
    logic        accepted;
    logic [2:0]  status;
    logic [1:0]  ack_ev;

    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance || !r_in_valid) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req       <= i_req_type;
            r_byte      <= i_rx_byte;
            r_cmd_class <= i_cmd_class;
            r_cmd_id    <= i_cmd_id;
        end
    end

    gfr_frame_rx u_rx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_is_byte (r_req == REQ_BYTE),
        .i_byte    (r_byte),
        .o_res     (rx_res)
    );

    gfr_cmd_track u_trk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_req         (r_req),
        .i_cmd_class   (r_cmd_class),
        .i_cmd_id      (r_cmd_id),
        .i_rx          (rx_res),
        .o_accepted    (accepted),
        .o_status      (status),
        .o_ack_ev      (ack_ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            o_payload_valid <= rx_res.payload_valid;
            o_payload_byte  <= rx_res.payload_byte;
            o_frame_done    <= rx_res.frame_done;
            o_frame_ok      <= rx_res.frame_ok;
            o_msg_class     <= rx_res.msg_class;
            o_msg_id        <= rx_res.msg_id;
            o_msg_length    <= rx_res.msg_length;
            o_cmd_accepted  <= accepted;
            o_cmd_status    <= status;
            o_ack_event     <= ack_ev;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: design/gfr_checker.sv
// Port-level checker for the frame receiver and acknowledge tracker, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module gfr_checker
    import gfr_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_payload_valid,
    input wire logic [7:0]  o_payload_byte,
    input wire logic        o_frame_done,
    input wire logic        o_frame_ok,
    input wire logic        o_cmd_accepted,
    input wire logic [2:0]  o_cmd_status,
    input wire logic [1:0]  o_ack_event
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_payload_byte)
            && $stable(o_cmd_status) && $stable(o_ack_event))
        else $error("stalled output word changed");

    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_ok |-> o_frame_done && !o_payload_valid)
        else $error("frame_ok without frame end");

    a_ack_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ack_event != EV_NONE |->
            o_frame_ok && ((o_ack_event == EV_ACK && o_cmd_status == STAT_ACKED)
            || (o_ack_event == EV_NAK && o_cmd_status == STAT_NACKED)))
        else $error("acknowledge event disagrees with tracker status");

    a_issue_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cmd_accepted |-> o_cmd_status == STAT_WAITING
            && !o_frame_done && !o_payload_valid)
        else $error("accepted command not waiting");

endmodule

bind gnss_frame_receiver_ack_tracker gfr_checker u_gfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_payload_valid (o_payload_valid),
    .o_payload_byte  (o_payload_byte),
    .o_frame_done    (o_frame_done),
    .o_frame_ok      (o_frame_ok),
    .o_cmd_accepted  (o_cmd_accepted),
    .o_cmd_status    (o_cmd_status),
    .o_ack_event     (o_ack_event)
);
`default_nettype wire

FILE: verif/gfr_rx_checker.sv
// Checker for the frame receiver: predicts every result word and compares it with the block.
`timescale 1ns / 1ps
module gfr_rx_checker
    import gfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [7:0]  i_cmd_class,
    input  wire logic [7:0]  i_cmd_id,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic        i_payload_valid,
    input  wire logic [7:0]  i_payload_byte,
    input  wire logic        i_frame_done,
    input  wire logic        i_frame_ok,
    input  wire logic [7:0]  i_msg_class,
    input  wire logic [7:0]  i_msg_id,
    input  wire logic [15:0] i_msg_length,
    input  wire logic        i_cmd_accepted,
    input  wire logic [2:0]  i_cmd_status,
    input  wire logic [1:0]  i_ack_event,
    output int               o_words_due,
    output int               o_fail_count
);

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        logic        frame_ok;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] msg_length;
        logic        cmd_accepted;
        t_status     cmd_status;
        t_ack_ev     ack_event;
    } t_rx_reply;

    t_phase      phase;
    logic [7:0]  hdr_class;
    logic [7:0]  hdr_id;
    logic [15:0] hdr_len;
    logic [15:0] pay_count;
    logic [7:0]  fl_a;
    logic [7:0]  fl_b;
    logic [7:0]  rx_ck_a;
    logic [7:0]  ack_cls;
    logic [7:0]  ack_msg;
    t_status     cmd_state;
    logic [7:0]  want_cls;
    logic [7:0]  want_id;
    logic [15:0] tick_count;
    logic [15:0] tmo_limit;
    t_rx_reply   replies_due[$];
    int          fails = 0;

    function automatic void fletcher_add(input logic [7:0] b);
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
    endfunction

    function automatic t_rx_reply predict_word(input logic [1:0] req, input logic [7:0] rx,
                                               input logic [7:0] cls, input logic [7:0] id);
        t_rx_reply r;
        logic      ck_ok;
        r = '0;
        if (req == REQ_BYTE) begin
            case (phase)
                PH_SYNC1: begin
                    if (rx == SYNC_FIRST) phase = PH_SYNC2;
                end
                PH_SYNC2: begin
                    if (rx == SYNC_SECOND) begin
                        phase = PH_CLASS;
                        fl_a = '0;
                        fl_b = '0;
                    end else if (rx != SYNC_FIRST) begin
                        phase = PH_SYNC1;
                    end
                end
                PH_CLASS: begin
                    hdr_class = rx;
                    fletcher_add(rx);
                    phase = PH_ID;
                end
                PH_ID: begin
                    hdr_id = rx;
                    fletcher_add(rx);
                    phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    hdr_len = {8'h00, rx};
                    fletcher_add(rx);
                    phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    hdr_len[15:8] = rx;
                    fletcher_add(rx);
                    pay_count = '0;
                    if (hdr_len == 16'd0) phase = PH_CK_A;
                    else phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    fletcher_add(rx);
                    r.payload_valid = 1'b1;
                    r.payload_byte  = rx;
                    if (pay_count == 16'd0) ack_cls = rx;
                    else if (pay_count == 16'd1) ack_msg = rx;
                    pay_count = pay_count + 16'd1;
                    if (pay_count >= hdr_len) phase = PH_CK_A;
                end
                PH_CK_A: begin
                    rx_ck_a = rx;
                    phase = PH_CK_B;
                end
                PH_CK_B: begin
                    ck_ok = (rx_ck_a == fl_a) && (rx == fl_b);
                    r.frame_done = 1'b1;
                    r.frame_ok   = ck_ok;
                    phase = PH_SYNC1;
                    if (ck_ok && hdr_class == ACK_CLASS && hdr_len == ACK_LEN &&
                        cmd_state == STAT_WAITING && ack_cls == want_cls && ack_msg == want_id) begin
                        if (hdr_id == ACK_ID_ACK) begin
                            cmd_state   = STAT_ACKED;
                            r.ack_event = EV_ACK;
                        end else begin
                            cmd_state   = STAT_NACKED;
                            r.ack_event = EV_NAK;
                        end
                    end
                end
                default: phase = PH_SYNC1;
            endcase
        end else if (req == REQ_ISSUE) begin
            if (cmd_state != STAT_WAITING) begin
                want_cls       = cls;
                want_id        = id;
                cmd_state      = STAT_WAITING;
                tick_count     = '0;
                r.cmd_accepted = 1'b1;
            end
        end else if (req == REQ_TICK) begin
            if (cmd_state == STAT_WAITING) begin
                if (tick_count != ELAPSED_MAX) tick_count = tick_count + 16'd1;
                if (tick_count >= tmo_limit) cmd_state = STAT_TIMEOUT;
            end
        end
        r.msg_class  = hdr_class;
        r.msg_id     = hdr_id;
        r.msg_length = hdr_len;
        r.cmd_status = cmd_state;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rx_reply want;
        if (!i_rst_n) begin
            phase      = PH_SYNC1;
            hdr_class  = '0;
            hdr_id     = '0;
            hdr_len    = '0;
            pay_count  = '0;
            fl_a       = '0;
            fl_b       = '0;
            rx_ck_a    = '0;
            ack_cls    = '0;
            ack_msg    = '0;
            cmd_state  = STAT_IDLE;
            want_cls   = '0;
            want_id    = '0;
            tick_count = '0;
            tmo_limit  = TIMEOUT_RESET;
            replies_due.delete();
        end else begin
            if (i_cfg_wr_en) tmo_limit = i_cfg_wr_data;
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $error("result word with none expected");
                    fails++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("payload_valid", want.payload_valid, i_payload_valid);
                    check_field("payload_byte", want.payload_byte, i_payload_byte);
                    check_field("frame_done", want.frame_done, i_frame_done);
                    check_field("frame_ok", want.frame_ok, i_frame_ok);
                    check_field("msg_class", want.msg_class, i_msg_class);
                    check_field("msg_id", want.msg_id, i_msg_id);
                    check_field("msg_length", want.msg_length, i_msg_length);
                    check_field("cmd_accepted", want.cmd_accepted, i_cmd_accepted);
                    check_field("cmd_status", want.cmd_status, i_cmd_status);
                    check_field("ack_event", want.ack_event, i_ack_event);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                replies_due.push_back(predict_word(i_req_type, i_rx_byte, i_cmd_class, i_cmd_id));
            end
        end
        o_words_due  <= replies_due.size();
        o_fail_count <= fails;
    end

endmodule

FILE: verif/tb_top.sv
// Testbench top: drives frames, commands and ticks into the receiver and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
    import gfr_pkg::*;

    localparam logic [1:0] REQ_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_req_type = '0;
    logic [7:0]  i_rx_byte = '0;
    logic [7:0]  i_cmd_class = '0;
    logic [7:0]  i_cmd_id = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_payload_valid;
    logic [7:0]  o_payload_byte;
    logic        o_frame_done;
    logic        o_frame_ok;
    logic [7:0]  o_msg_class;
    logic [7:0]  o_msg_id;
    logic [15:0] o_msg_length;
    logic        o_cmd_accepted;
    logic [2:0]  o_cmd_status;
    logic [1:0]  o_ack_event;

    int          words_due;
    int          fail_count;
    int          word_total = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          mix_pct = 0;
    logic [7:0]  last_cls = '0;
    logic [7:0]  last_id = '0;

    gnss_frame_receiver_ack_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_rx_byte       (i_rx_byte),
        .i_cmd_class     (i_cmd_class),
        .i_cmd_id        (i_cmd_id),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_frame_done    (o_frame_done),
        .o_frame_ok      (o_frame_ok),
        .o_msg_class     (o_msg_class),
        .o_msg_id        (o_msg_id),
        .o_msg_length    (o_msg_length),
        .o_cmd_accepted  (o_cmd_accepted),
        .o_cmd_status    (o_cmd_status),
        .o_ack_event     (o_ack_event)
    );

    gfr_rx_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_rx_byte       (i_rx_byte),
        .i_cmd_class     (i_cmd_class),
        .i_cmd_id        (i_cmd_id),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_payload_valid (o_payload_valid),
        .i_payload_byte  (o_payload_byte),
        .i_frame_done    (o_frame_done),
        .i_frame_ok      (o_frame_ok),
        .i_msg_class     (o_msg_class),
        .i_msg_id        (o_msg_id),
        .i_msg_length    (o_msg_length),
        .i_cmd_accepted  (o_cmd_accepted),
        .i_cmd_status    (o_cmd_status),
        .i_ack_event     (o_ack_event),
        .o_words_due     (words_due),
        .o_fail_count    (fail_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_word(input logic [1:0] req, input logic [7:0] rx,
                            input logic [7:0] cls, input logic [7:0] id);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_rx_byte   <= rx;
        i_cmd_class <= cls;
        i_cmd_id    <= id;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        word_total++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        put_word(REQ_BYTE, b, rnd8(), rnd8());
    endtask

    task automatic put_tick();
        put_word(REQ_TICK, rnd8(), rnd8(), rnd8());
    endtask

    task automatic put_stray();
        case ($urandom_range(0, 3))
            0:       put_word(REQ_ISSUE, rnd8(), rnd8(), rnd8());
            1:       put_word(REQ_SPARE, rnd8(), rnd8(), rnd8());
            default: put_tick();
        endcase
    endtask

    // cut >= 0 breaks the frame off after that many bytes and flushes the parser with zeros
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id, input logic [15:0] len,
                              input logic [7:0] p0, input logic [7:0] p1,
                              input logic [15:0] ck_flip, input int cut);
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] b;
        logic [7:0] hdr[4];
        int         total;
        ck_a  = '0;
        ck_b  = '0;
        hdr   = '{cls, id, len[7:0], len[15:8]};
        total = int'(len) + 8;
        for (int k = 0; k < total; k++) begin
            if (k == cut) break;
            if (k == 0) b = SYNC_FIRST;
            else if (k == 1) b = SYNC_SECOND;
            else if (k < 6) b = hdr[k - 2];
            else if (k == total - 2) b = ck_a ^ ck_flip[7:0];
            else if (k == total - 1) b = ck_b ^ ck_flip[15:8];
            else if (k == 6) b = p0;
            else if (k == 7) b = p1;
            else b = rnd8();
            if (k >= 2 && k < total - 2) begin
                ck_a = ck_a + b;
                ck_b = ck_b + ck_a;
            end
            put_byte(b);
            if ($urandom_range(0, 99) < mix_pct) put_stray();
        end
        if (cut >= 0 && cut < total) repeat (16) put_byte(8'h00);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_due != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= ticks;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_traffic(input int words);
        int          stop;
        int          pick;
        logic [15:0] plen;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  b;
        stop = word_total + words;
        while (word_total < stop) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) plen = 16'($urandom_range(9, 40));
            else plen = 16'($urandom_range(0, 8));
            if (pick < 35) begin
                send_frame(rnd8(), rnd8(), plen, rnd8(), rnd8(), '0, -1);
            end else if (pick < 55) begin
                d = ($urandom_range(0, 1) == 0) ? ACK_ID_ACK : rnd8();
                send_frame(ACK_CLASS, d, ($urandom_range(0, 7) == 0) ? 16'd3 : ACK_LEN,
                           ($urandom_range(0, 7) == 0) ? rnd8() : last_cls,
                           ($urandom_range(0, 7) == 0) ? rnd8() : last_id,
                           ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0,
                           -1);
            end else if (pick < 65) begin
                c = rnd8();
                d = rnd8();
                if (o_cmd_status != STAT_WAITING) begin
                    last_cls = c;
                    last_id  = d;
                end
                put_word(REQ_ISSUE, rnd8(), c, d);
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 12)) put_tick();
            end else if (pick < 88) begin
                send_frame(rnd8(), rnd8(), plen, rnd8(), rnd8(),
                           16'($urandom_range(1, 65535)), -1);
            end else if (pick < 94) begin
                plen = 16'($urandom_range(0, 8));
                send_frame(rnd8(), rnd8(), plen, rnd8(), rnd8(), '0,
                           $urandom_range(1, int'(plen) + 7));
            end else if (pick < 98) begin
                case ($urandom_range(0, 2))
                    0: begin
                        repeat ($urandom_range(1, 6)) begin
                            b = rnd8();
                            if (b == SYNC_FIRST) b = 8'h00;
                            put_byte(b);
                        end
                    end
                    1: begin
                        b = rnd8();
                        if (b == SYNC_FIRST || b == SYNC_SECOND) b = 8'hFF;
                        put_byte(SYNC_FIRST);
                        put_byte(b);
                    end
                    default: begin
                        put_byte(SYNC_FIRST);
                        send_frame(rnd8(), rnd8(), plen, rnd8(), rnd8(), '0, -1);
                    end
                endcase
            end else begin
                put_word(REQ_SPARE, rnd8(), rnd8(), rnd8());
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct  = 20;
        stall_pct = 8;
        put_tick();
        put_word(REQ_SPARE, 8'hFF, 8'hFF, 8'hFF);
        put_word(REQ_ISSUE, 8'h00, 8'hFF, 8'h00);
        put_word(REQ_ISSUE, 8'hFF, 8'h00, 8'hFF);
        put_byte(SYNC_FIRST);
        send_frame(ACK_CLASS, ACK_ID_ACK, ACK_LEN, 8'hFF, 8'h00, '0, -1);
        put_byte(SYNC_FIRST);
        put_byte(8'h00);
        send_frame(8'hFF, 8'hFF, 16'h0000, 8'h00, 8'h00, 16'h0101, -1);
        last_cls = 8'hFF;
        last_id  = 8'h00;

        idle_pct  = 25;
        stall_pct = 10;
        mix_pct   = 10;
        random_traffic(200);

        set_timeout(16'd1);
        idle_pct  = 0;
        stall_pct = 0;
        random_traffic(180);

        set_timeout(16'd0);
        idle_pct  = 40;
        stall_pct = 15;
        random_traffic(130);

        set_timeout(16'd20);
        idle_pct  = 15;
        stall_pct = 25;
        random_traffic(220);

        // timeout reached and a long frame, back to back
        set_timeout(16'd30);
        idle_pct  = 0;
        stall_pct = 0;
        mix_pct   = 0;
        put_word(REQ_ISSUE, rnd8(), rnd8(), rnd8());
        repeat (31) put_tick();
        put_tick();
        send_frame(rnd8(), rnd8(), 16'd48, rnd8(), rnd8(), '0, -1);

        set_timeout(16'd3);
        mix_pct = 10;
        random_traffic(220);

        drain();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/gfr_pkg.sv
design/gfr_frame_rx.sv
design/gfr_cmd_track.sv
design/gnss_frame_receiver_ack_tracker.sv
design/gfr_checker.sv
verif/gfr_rx_checker.sv
verif/tb_top.sv
